>>> hdl/sslo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslo_pkg: shared types and constants of the slew and soft limit block
// Holds the sequencer states, the pitch zone codes, the configuration
// bundle with its precomputed zone bounds, and the fixed-point widths.
// ----------------------------------------------------------------------------
package sslo_pkg;

  // Width of the zone arithmetic, which works at twenty times position scale.
  localparam int ZW = 23;
  // Width of the zone divider operands and of its quotient.
  localparam int NW = 19;
  localparam int QW = 14;
  // Width of the serial multiplier operands.
  localparam int MW = 16;

  localparam logic [14:0] ONE_Q14 = 15'd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZONE,
    ST_DIV,
    ST_SCALE,
    ST_DONE
  } sslo_state_t;

  typedef enum logic [2:0] {
    ZN_NONE,
    ZN_TOP_SLOW,
    ZN_ABOVE,
    ZN_BOT_SLOW,
    ZN_BELOW
  } sslo_zone_t;

  typedef struct packed {
    logic signed [15:0]   travel_max;
    logic signed [15:0]   travel_min;
    logic [15:0]          step_time;
    logic signed [ZW-1:0] top20;
    logic signed [ZW-1:0] bot20;
    logic signed [ZW-1:0] den6;
    logic signed [ZW-1:0] den3;
  } sslo_cfg_t;

endpackage

>>> hdl/sslo_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslo_in_if: input channel of the slew and soft limit block
// Carries one tick of demands, limits, rates and the measured pitch.
// ----------------------------------------------------------------------------
interface sslo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_demand;
  logic signed [15:0] yaw_demand;
  logic [14:0]        pitch_limit;
  logic [14:0]        yaw_limit;
  logic [15:0]        pitch_rate;
  logic [15:0]        yaw_rate;
  logic signed [15:0] measured_pitch;

  modport source (
    output valid, pitch_demand, yaw_demand, pitch_limit, yaw_limit,
           pitch_rate, yaw_rate, measured_pitch,
    input  ready
  );

  modport sink (
    input  valid, pitch_demand, yaw_demand, pitch_limit, yaw_limit,
           pitch_rate, yaw_rate, measured_pitch,
    output ready
  );
endinterface

>>> hdl/sslo_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslo_out_if: result channel of the slew and soft limit block
// Carries the limited pitch and yaw drive values of one tick.
// ----------------------------------------------------------------------------
interface sslo_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_drive;
  logic signed [15:0] yaw_drive;

  modport source (
    output valid, pitch_drive, yaw_drive,
    input  ready
  );

  modport sink (
    input  valid, pitch_drive, yaw_drive,
    output ready
  );
endinterface

>>> hdl/sslo_smul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslo_smul: radix-4 serial multiplier
// Unsigned shift-add multiplier that retires two multiplier bits per cycle.
// BW must be even; the product is valid once busy falls.
// ----------------------------------------------------------------------------
module sslo_smul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] product
);

  localparam int CW = $clog2(BW / 2 + 1);
  localparam logic [CW-1:0] STEPS = CW'(BW / 2);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [BW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] a1_r;
  logic [AW+1:0] a3_r;
  logic [AW+1:0] addend;
  logic [AW+1:0] sum;

  assign busy    = (cnt_r != '0);
  assign product = {hi_r, lo_r};

  always_comb begin
    case (lo_r[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, a1_r};
      2'd2:    addend = {1'b0, a1_r, 1'b0};
      default: addend = a3_r;
    endcase
    sum    = {2'b00, hi_r} + addend;
    hi_nxt = sum[AW+1:2];
    lo_nxt = {sum[1:0], lo_r[BW-1:2]};
    if (start) begin
      cnt_nxt = STEPS;
    end else if (busy) begin
      cnt_nxt = cnt_r - CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a1_r <= a;
      a3_r <= {2'b00, a} + {1'b0, a, 1'b0};
      hi_r <= '0;
      lo_r <= b;
    end else if (busy) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

endmodule

>>> hdl/sslo_sdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslo_sdiv: serial fraction divider
// Restoring divider that forms floor(num * 2^QW / den) one quotient bit per
// cycle, for num below den. The quotient is valid once busy falls.
// ----------------------------------------------------------------------------
module sslo_sdiv #(
  parameter int NW = 19,
  parameter int QW = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quot
);

  localparam int CW = $clog2(QW + 1);
  localparam logic [CW-1:0] STEPS = CW'(QW);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] den_r;
  logic [QW-1:0] quot_r, quot_nxt;
  logic [NW:0]   shifted;
  logic [NW+1:0] diff;
  logic          take;

  assign busy = (cnt_r != '0);
  assign quot = quot_r;

  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = {1'b0, shifted} - {2'b00, den_r};
    take     = !diff[NW+1];
    rem_nxt  = take ? diff[NW-1:0] : shifted[NW-1:0];
    quot_nxt = {quot_r[QW-2:0], take};
    if (start) begin
      cnt_nxt = STEPS;
    end else if (busy) begin
      cnt_nxt = cnt_r - CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
    end else if (busy) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

endmodule

>>> hdl/sslo_apb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslo_apb: configuration registers
// APB-style register file for the travel ends and the tick period. It also
// keeps the slow zone bounds and zone widths, at twenty times position
// scale, in registers updated the cycle after the travel registers change.
// ----------------------------------------------------------------------------
module sslo_apb (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output sslo_pkg::sslo_cfg_t cfg
);

  import sslo_pkg::*;

  localparam logic [1:0] REG_TRAVEL_MAX = 2'd0;
  localparam logic [1:0] REG_TRAVEL_MIN = 2'd1;
  localparam logic [1:0] REG_STEP_TIME  = 2'd2;

  localparam logic [15:0] TRAVEL_MAX_RST = 16'h7FFF;
  localparam logic [15:0] TRAVEL_MIN_RST = 16'h8000;
  localparam logic [15:0] STEP_TIME_RST  = 16'd655;

  logic                 wr_en;
  logic [15:0]          travel_max_r;
  logic [15:0]          travel_min_r;
  logic [15:0]          step_time_r;
  logic signed [ZW-1:0] mx_w;
  logic signed [ZW-1:0] mn_w;
  logic signed [ZW-1:0] travel;
  logic signed [ZW-1:0] top20_r, top20_nxt;
  logic signed [ZW-1:0] bot20_r, bot20_nxt;
  logic signed [ZW-1:0] den6_r, den6_nxt;
  logic signed [ZW-1:0] den3_r, den3_nxt;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_TRAVEL_MAX: prdata = {16'h0000, travel_max_r};
      REG_TRAVEL_MIN: prdata = {16'h0000, travel_min_r};
      REG_STEP_TIME:  prdata = {16'h0000, step_time_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_max_r <= TRAVEL_MAX_RST;
      travel_min_r <= TRAVEL_MIN_RST;
      step_time_r  <= STEP_TIME_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_TRAVEL_MAX: travel_max_r <= pwdata[15:0];
        REG_TRAVEL_MIN: travel_min_r <= pwdata[15:0];
        REG_STEP_TIME:  step_time_r  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mx_w      = {{(ZW-16){travel_max_r[15]}}, travel_max_r};
    mn_w      = {{(ZW-16){travel_min_r[15]}}, travel_min_r};
    travel    = mx_w - mn_w;
    den6_nxt  = (travel <<< 2) + (travel <<< 1);
    den3_nxt  = (travel <<< 1) + travel;
    top20_nxt = (mx_w <<< 4) + (mx_w <<< 2) - den6_nxt;
    bot20_nxt = (mn_w <<< 4) + (mn_w <<< 2) + den3_nxt;
  end

  always_ff @(posedge clk) begin
    top20_r <= top20_nxt;
    bot20_r <= bot20_nxt;
    den6_r  <= den6_nxt;
    den3_r  <= den3_nxt;
  end

  always_comb begin
    cfg.travel_max = travel_max_r;
    cfg.travel_min = travel_min_r;
    cfg.step_time  = step_time_r;
    cfg.top20      = top20_r;
    cfg.bot20      = bot20_r;
    cfg.den6       = den6_r;
    cfg.den3       = den3_r;
  end

endmodule

>>> hdl/slew_and_soft_limit_output.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slew_and_soft_limit_output: slew-rate limiter with soft pitch end stops
// Each transfer on in_ch is one control tick. Both demands are clamped to
// plus or minus one (Q2.14), the held pitch and yaw levels ramp toward them
// by at most rate times step time, pitch motion toward a travel end is
// reduced inside the slow zones and blocked past an end, and both levels are
// clamped to their speed limits. One result per tick leaves on out_ch.
// The travel ends and the tick period are to be written over the APB-style
// port only while no tick is in flight; the block does not enforce this.
// From its input transfer to its result, a tick goes through these steps:
// the ST_ZONE state selects the pitch zone, the 14-bit serial zone divider
// runs while two radix-4 serial multipliers form the ramp steps, and the
// pitch multiplier then scales the speed limit. in_ch.ready is high only
// between ticks, so a new tick waits until the last one has left ST_DONE.
// A result waits in the output register while the receiver stalls; the next
// tick is still accepted and computed, and it waits for that register.
// Reset clears both held levels to zero, empties the output register and
// loads the registers with their reset values.
// ----------------------------------------------------------------------------
module slew_and_soft_limit_output (
  input  logic        clk,
  input  logic        rst_n,
  sslo_in_if.sink     in_ch,
  sslo_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import sslo_pkg::*;

  localparam logic signed [17:0] DEM_MAX = 18'sd16384;

  function automatic logic signed [17:0] clamp18(input logic signed [17:0] x,
                                                 input logic signed [17:0] lo,
                                                 input logic signed [17:0] hi);
    logic signed [17:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] ramp16(input logic signed [15:0] level,
                                                input logic signed [15:0] demand,
                                                input logic [15:0] step);
    logic signed [17:0] lv;
    logic signed [17:0] dm;
    logic signed [17:0] st;
    logic signed [17:0] moved;
    logic signed [17:0] r;
    lv = {{2{level[15]}}, level};
    dm = {{2{demand[15]}}, demand};
    st = {2'b00, step};
    if (lv < dm) begin
      moved = lv + st;
      r = (moved > dm) ? dm : moved;
    end else if (lv > dm) begin
      moved = lv - st;
      r = (moved < dm) ? dm : moved;
    end else begin
      r = lv;
    end
    return r[15:0];
  endfunction

  sslo_cfg_t          cfg;
  sslo_state_t        state_r, state_nxt;
  sslo_zone_t         zone_r, zone_nxt, zone_sel;

  logic               in_fire;
  logic               unit_go;
  logic               scale_go;
  logic               ramp_cap;
  logic               load_out;

  logic signed [15:0] dp_r, dp_nxt;
  logic signed [15:0] dy_r, dy_nxt;
  logic [14:0]        ps_r;
  logic [14:0]        ys_r;
  logic [15:0]        pr_r;
  logic [15:0]        yr_r;
  logic signed [15:0] meas_r;
  logic signed [ZW-1:0] m20_r, m20_nxt;
  logic signed [ZW-1:0] meas_ext;
  logic signed [17:0] dp_in;
  logic signed [17:0] dy_in;

  logic signed [ZW-1:0] dt;
  logic signed [ZW-1:0] db;
  logic               in_top;
  logic               in_bot;

  logic [MW-1:0]      mp_a;
  logic [MW-1:0]      mp_b;
  logic               mp_start;
  logic               mp_busy;
  logic [2*MW-1:0]    mp_prod;
  logic               my_busy;
  logic [2*MW-1:0]    my_prod;
  logic [NW-1:0]      dv_num;
  logic [NW-1:0]      dv_den;
  logic               dv_busy;
  logic [QW-1:0]      dv_quot;
  logic [14:0]        pc;

  logic signed [15:0] p_ramp_w;
  logic signed [15:0] y_ramp_w;
  logic signed [15:0] p_ramp_r;
  logic signed [15:0] y_ramp_r;
  logic signed [15:0] pitch_level_r;
  logic signed [15:0] yaw_level_r;

  logic signed [17:0] ps18;
  logic signed [17:0] ys18;
  logic signed [17:0] sc18;
  logic signed [17:0] lo_b;
  logic signed [17:0] hi_b;
  logic signed [17:0] p_soft;
  logic signed [17:0] p_fin;
  logic signed [17:0] y_fin;

  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] pitch_drive_r;
  logic signed [15:0] yaw_drive_r;

  sslo_apb u_apb (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sslo_smul #(.AW(MW), .BW(MW)) u_mul_p (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mp_start),
    .a       (mp_a),
    .b       (mp_b),
    .busy    (mp_busy),
    .product (mp_prod)
  );

  sslo_smul #(.AW(MW), .BW(MW)) u_mul_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (unit_go),
    .a       (cfg.step_time),
    .b       (yr_r),
    .busy    (my_busy),
    .product (my_prod)
  );

  sslo_sdiv #(.NW(NW), .QW(QW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_go),
    .num   (dv_num),
    .den   (dv_den),
    .busy  (dv_busy),
    .quot  (dv_quot)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_fire            = in_ch.valid && (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.pitch_drive = pitch_drive_r;
  assign out_ch.yaw_drive   = yaw_drive_r;

  always_comb begin
    dp_in    = {{2{in_ch.pitch_demand[15]}}, in_ch.pitch_demand};
    dy_in    = {{2{in_ch.yaw_demand[15]}}, in_ch.yaw_demand};
    dp_nxt   = 16'(clamp18(dp_in, -DEM_MAX, DEM_MAX));
    dy_nxt   = 16'(clamp18(dy_in, -DEM_MAX, DEM_MAX));
    meas_ext = {{(ZW-16){in_ch.measured_pitch[15]}}, in_ch.measured_pitch};
    m20_nxt  = (meas_ext <<< 4) + (meas_ext <<< 2);
  end

  always_comb begin
    dt     = m20_r - cfg.top20;
    db     = cfg.bot20 - m20_r;
    in_top = !dt[ZW-1] && (dt != '0) && (meas_r < cfg.travel_max);
    in_bot = !db[ZW-1] && (db != '0) && (meas_r > cfg.travel_min);
    if (in_top) begin
      zone_sel = ZN_TOP_SLOW;
    end else if (meas_r > cfg.travel_max) begin
      zone_sel = ZN_ABOVE;
    end else if (in_bot) begin
      zone_sel = ZN_BOT_SLOW;
    end else if (meas_r < cfg.travel_min) begin
      zone_sel = ZN_BELOW;
    end else begin
      zone_sel = ZN_NONE;
    end
    dv_num = in_top ? dt[NW-1:0] : db[NW-1:0];
    dv_den = in_top ? cfg.den6[NW-1:0] : cfg.den3[NW-1:0];
  end

  always_comb begin
    pc       = ONE_Q14 - {1'b0, dv_quot};
    mp_start = unit_go || scale_go;
    mp_a     = (state_r == ST_ZONE) ? cfg.step_time : {1'b0, ps_r};
    mp_b     = (state_r == ST_ZONE) ? pr_r : {1'b0, pc};
    p_ramp_w = ramp16(pitch_level_r, dp_r, mp_prod[31:16]);
    y_ramp_w = ramp16(yaw_level_r, dy_r, my_prod[31:16]);
  end

  always_comb begin
    ps18 = {3'b000, ps_r};
    ys18 = {3'b000, ys_r};
    sc18 = {3'b000, mp_prod[28:14]};
    case (zone_r)
      ZN_TOP_SLOW: begin
        lo_b = -sc18;
        hi_b = ps18;
      end
      ZN_ABOVE: begin
        lo_b = '0;
        hi_b = ps18;
      end
      ZN_BOT_SLOW: begin
        lo_b = -ps18;
        hi_b = sc18;
      end
      ZN_BELOW: begin
        lo_b = -ps18;
        hi_b = '0;
      end
      default: begin
        lo_b = -ps18;
        hi_b = ps18;
      end
    endcase
    p_soft = clamp18({{2{p_ramp_r[15]}}, p_ramp_r}, lo_b, hi_b);
    p_fin  = clamp18(p_soft, -ps18, ps18);
    y_fin  = clamp18({{2{y_ramp_r[15]}}, y_ramp_r}, -ys18, ys18);
  end

  always_comb begin
    state_nxt = state_r;
    unit_go   = 1'b0;
    scale_go  = 1'b0;
    ramp_cap  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_ZONE;
        end
      end
      ST_ZONE: begin
        unit_go   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!dv_busy && !mp_busy && !my_busy) begin
          ramp_cap  = 1'b1;
          scale_go  = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (!mp_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    zone_nxt      = (state_r == ST_ZONE) ? zone_sel : zone_r;
    out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      pitch_level_r <= '0;
      yaw_level_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        pitch_level_r <= p_fin[15:0];
        yaw_level_r   <= y_fin[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    zone_r <= zone_nxt;
    if (in_fire) begin
      dp_r   <= dp_nxt;
      dy_r   <= dy_nxt;
      ps_r   <= in_ch.pitch_limit;
      ys_r   <= in_ch.yaw_limit;
      pr_r   <= in_ch.pitch_rate;
      yr_r   <= in_ch.yaw_rate;
      meas_r <= in_ch.measured_pitch;
      m20_r  <= m20_nxt;
    end
    if (ramp_cap) begin
      p_ramp_r <= p_ramp_w;
      y_ramp_r <= y_ramp_w;
    end
    if (load_out) begin
      pitch_drive_r <= p_fin[15:0];
      yaw_drive_r   <= y_fin[15:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_ramp_no_overshoot: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_cap |-> ((p_ramp_w >= pitch_level_r) || (p_ramp_w >= dp_r)) &&
                 ((p_ramp_w <= pitch_level_r) || (p_ramp_w <= dp_r)))
    else $error("Pitch ramp passed beyond its level or demand.");

  a_pitch_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (p_fin <= ps18) && (p_fin >= -ps18))
    else $error("Pitch drive outside its speed limit.");

  a_div_before_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCALE) |-> !dv_busy)
    else $error("Speed limit scaled before the zone fraction was ready.");

  a_units_free_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_ZONE) && !mp_busy && !my_busy && !dv_busy)
    else $error("Serial units still busy when a new tick started.");
`endif

endmodule
